>>> rtl/core/bpa_pkg.sv
// Shared constants, codes and sizes for the bitmap page allocator.
// No dependencies; imported by the allocator core.
`default_nettype none

package bpa_pkg;

  // Number of pages the file may grow to.
  localparam int MAX_PAGES = 4096;

  // Fixed field widths of the request and response channels.
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int PAGE_ID_W = 12;
  localparam int COUNT_W   = 13;

  // Bitmap organization: one RAM word holds WORD_W page bits.
  localparam int WORD_W = (MAX_PAGES >= 128) ? 64 : MAX_PAGES / 2;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = MAX_PAGES / WORD_W;
  localparam int ROW_W  = $clog2(ROWS);

  // Internal page index and count widths.
  localparam int PG_W  = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);

  // Width used to compare a requested page number against the page count.
  localparam int CMP_W = (CNT_W > PAGE_ID_W + 1) ? CNT_W : PAGE_ID_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/bpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the allocation bitmap rows.
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_page_allocator_top.sv
// Bitmap page allocator: allocate, free and check pages of one file.
// Allocate searches the rows below the page count, stopping early when a clear page turns up;
// the bitmap RAM delivers one 64-bit row per cycle. Free and check need one RAM read, and
// an out-of-range page is answered without a RAM read.
// One request is in flight at a time; a new one is taken once the previous result is stored.
// Synchronous active-low reset; a per-row valid flag stands in for the bitmap, no clear pass.
`default_nettype none

module bitmap_page_allocator_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bpa_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [bpa_pkg::PAGE_ID_W-1:0] in_page_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [bpa_pkg::STATUS_W-1:0]  out_status,
  output logic      [bpa_pkg::PAGE_ID_W-1:0] out_result_page,
  output logic      [bpa_pkg::COUNT_W-1:0]   out_pages_in_file,
  output logic      [bpa_pkg::COUNT_W-1:0]   out_pages_in_use
);

  import bpa_pkg::*;

  // S_SCAN streams bitmap rows through the search unit, S_RD waits on the
  // RAM for a free or check request, S_EVAL tests the page bit, and S_RESP
  // hands the result to the output register once it is free.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_EVAL,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [PAGE_ID_W-1:0] pg_r, pg_nxt;
  logic [ROW_W-1:0]     rd_row_r, rd_row_nxt;
  logic [ROW_W-1:0]     data_row_r, data_row_nxt;
  logic                 data_vld_r, data_vld_nxt;
  logic                 issue_done_r, issue_done_nxt;
  logic [ROWS-1:0]      row_vld_r, row_vld_nxt;
  logic [CNT_W-1:0]     hw_r, hw_nxt;
  logic [CNT_W-1:0]     use_r, use_nxt;
  status_t              status_r, status_nxt;
  logic [PAGE_ID_W-1:0] res_page_r, res_page_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [PAGE_ID_W-1:0] out_page_r, out_page_nxt;
  logic [COUNT_W-1:0]   out_file_r, out_file_nxt;
  logic [COUNT_W-1:0]   out_use_r, out_use_nxt;

  // Bitmap RAM port signals.
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  bpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_row_r),
    .rdata(ram_rdata)
  );

  // A row that was never written holds its reset pattern: only page 0 is
  // marked, and it lives in row 0.
  logic [WORD_W-1:0] eff_word;
  assign eff_word = row_vld_r[data_row_r] ? ram_rdata :
                    ((data_row_r == '0) ? WORD_W'(1) : '0);

  // Pages at or above the page count are not candidates for the search.
  logic [CNT_W-BIT_W-1:0] hw_row_full;
  logic [CNT_W-BIT_W-1:0] data_row_ext;
  logic [WORD_W-1:0]      low_mask;
  logic [WORD_W-1:0]      avail_mask;
  logic [WORD_W-1:0]      free_vec;

  assign hw_row_full  = hw_r[CNT_W-1:BIT_W];
  assign data_row_ext = (CNT_W-BIT_W)'(data_row_r);
  assign low_mask     = (WORD_W'(1) << hw_r[BIT_W-1:0]) - WORD_W'(1);
  assign avail_mask   = (data_row_ext < hw_row_full)  ? '1 :
                        (data_row_ext == hw_row_full) ? low_mask : '0;
  assign free_vec     = ~eff_word & avail_mask;

  // Allocate search unit: lowest clear page bit of the current row.
  logic             found;
  logic [BIT_W-1:0] found_idx;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found     = 1'b1;
        found_idx = BIT_W'(i);
      end
    end
  end

  // Last row that holds pages below the page count, and the page that an
  // extension of the file would add.
  logic [CNT_W-1:0] hw_m1;
  logic [ROW_W-1:0] last_row;
  logic [PG_W-1:0]  hw_page;
  assign hw_m1    = hw_r - CNT_W'(1);
  assign last_row = hw_m1[PG_W-1:BIT_W];
  assign hw_page  = hw_r[PG_W-1:0];

  // Requested page split into row and bit, at a width that never truncates.
  logic [CMP_W-1:0] in_pg_ext;
  logic             in_pg_ok;
  logic [CMP_W-1:0] pg_ext;
  logic [BIT_W-1:0] pg_bit;
  assign in_pg_ext = CMP_W'(in_page_id);
  assign in_pg_ok  = in_pg_ext < CMP_W'(hw_r);
  assign pg_ext    = CMP_W'(pg_r);
  assign pg_bit    = pg_ext[BIT_W-1:0];

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pg_nxt         = pg_r;
    rd_row_nxt     = rd_row_r;
    data_row_nxt   = data_row_r;
    data_vld_nxt   = data_vld_r;
    issue_done_nxt = issue_done_r;
    row_vld_nxt    = row_vld_r;
    hw_nxt         = hw_r;
    use_nxt        = use_r;
    status_nxt     = status_r;
    res_page_nxt   = res_page_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_file_nxt   = out_file_r;
    out_use_nxt    = out_use_r;
    ram_we         = 1'b0;
    ram_waddr      = data_row_r;
    ram_wdata      = eff_word;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          pg_nxt     = in_page_id;
          status_nxt = ST_OK;
          if (in_cmd == CMD_ALLOC) begin
            rd_row_nxt     = '0;
            data_vld_nxt   = 1'b0;
            issue_done_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end else if (in_pg_ok) begin
            rd_row_nxt   = in_pg_ext[PG_W-1:BIT_W];
            data_row_nxt = in_pg_ext[PG_W-1:BIT_W];
            state_nxt    = S_RD;
          end else begin
            status_nxt   = ST_INVALID;
            res_page_nxt = in_page_id;
            state_nxt    = S_RESP;
          end
        end
      end

      S_SCAN: begin
        // Issue the next row read while the previous row is searched.
        data_row_nxt = rd_row_r;
        data_vld_nxt = !issue_done_r;
        if (rd_row_r == last_row) begin
          issue_done_nxt = 1'b1;
        end else begin
          rd_row_nxt = rd_row_r + ROW_W'(1);
        end

        if (data_vld_r) begin
          if (found) begin
            ram_we                  = 1'b1;
            ram_waddr               = data_row_r;
            ram_wdata               = eff_word | (WORD_W'(1) << found_idx);
            row_vld_nxt[data_row_r] = 1'b1;
            use_nxt                 = use_r + CNT_W'(1);
            res_page_nxt            = PAGE_ID_W'({data_row_r, found_idx});
            state_nxt               = S_RESP;
          end else if (data_row_r == last_row) begin
            if (hw_r < CNT_W'(MAX_PAGES)) begin
              // The new page opens a fresh row when it sits on a row boundary;
              // otherwise it shares the row just searched.
              ram_we    = 1'b1;
              ram_waddr = hw_page[PG_W-1:BIT_W];
              ram_wdata = ((hw_r[BIT_W-1:0] == '0) ? '0 : eff_word) |
                          (WORD_W'(1) << hw_r[BIT_W-1:0]);
              row_vld_nxt[hw_page[PG_W-1:BIT_W]] = 1'b1;
              hw_nxt       = hw_r + CNT_W'(1);
              use_nxt      = use_r + CNT_W'(1);
              res_page_nxt = PAGE_ID_W'(hw_page);
            end else begin
              status_nxt   = ST_NO_SPACE;
              res_page_nxt = pg_r;
            end
            state_nxt = S_RESP;
          end
        end
      end

      S_RD: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        res_page_nxt = pg_r;
        if (!eff_word[pg_bit]) begin
          status_nxt = ST_INVALID;
        end else if (cmd_r == CMD_FREE) begin
          ram_we                  = 1'b1;
          ram_waddr               = data_row_r;
          ram_wdata               = eff_word & ~(WORD_W'(1) << pg_bit);
          row_vld_nxt[data_row_r] = 1'b1;
          if (use_r != '0) begin
            use_nxt = use_r - CNT_W'(1);
          end
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_page_nxt   = res_page_r;
          out_file_nxt   = COUNT_W'(hw_r);
          out_use_nxt    = COUNT_W'(use_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      data_vld_r   <= 1'b0;
      issue_done_r <= 1'b0;
      row_vld_r    <= '0;
      hw_r         <= CNT_W'(1);
      use_r        <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      data_vld_r   <= data_vld_nxt;
      issue_done_r <= issue_done_nxt;
      row_vld_r    <= row_vld_nxt;
      hw_r         <= hw_nxt;
      use_r        <= use_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    pg_r         <= pg_nxt;
    rd_row_r     <= rd_row_nxt;
    data_row_r   <= data_row_nxt;
    status_r     <= status_nxt;
    res_page_r   <= res_page_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_file_r   <= out_file_nxt;
    out_use_r    <= out_use_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_page   = out_page_r;
  assign out_pages_in_file = out_file_r;
  assign out_pages_in_use  = out_use_r;

endmodule

`default_nettype wire
